// ----- src/stip_pkg.sv -----
`default_nettype none

package stip_pkg;

   localparam int SPEEDS_DEFAULT = 16;
   localparam int STEERS_DEFAULT = 64;

   localparam int VAL_W      = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int SPD_REG_W  = 5;
   localparam int STR_REG_W  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEEDS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEERS = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic [1:0] {
      ACT_WR_SPEED = 2'd0,
      ACT_WR_STEER = 2'd1,
      ACT_WR_CELL  = 2'd2,
      ACT_LOOKUP   = 2'd3
   } stip_action_type;

   typedef struct packed {
      stip_action_type           action;
      logic [5:0]                row_index;
      logic [3:0]                col_index;
      logic signed [VAL_W-1:0]   table_value;
      logic                      cell_valid;
      logic signed [VAL_W-1:0]   lookup_accel;
      logic signed [VAL_W-1:0]   lookup_speed;
   } stip_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]   steer_out;
      logic                      status;
   } stip_rsp_type;

   typedef struct packed {
      logic wr;
      logic load;
      logic scan_clr;
      logic spd_scan;
      logic cel_scan;
      logic cap_sec;
      logic sel_second;
      logic cap_y0;
      logic cap_y1;
      logic div_start;
      logic fin;
      logic rsp_load;
   } stip_cmd_type;

   typedef struct packed {
      logic spd_done;
      logic cel_done;
      logic cel_empty;
      logic div_done;
      logic rsp_free;
   } stip_stat_type;

endpackage

`default_nettype wire

// ----- src/stip_div.sv -----
`default_nettype none

module stip_div #(
   parameter int NW = 51,
   parameter int DW = 25
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [NW-1:0]      quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dvs_ff;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_sub;
   logic          ge;

   assign rem_sh  = {rem_ff, quo_ff[NW-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[NW-2:0], ge};
         rem_ff <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      end
   end

   assign done     = (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/stip_ctrl.sv -----
`default_nettype none

module stip_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire stip_pkg::stip_action_type req_action,
   output logic                          req_stall,
   output stip_pkg::stip_cmd_type        cmd,
   input  wire stip_pkg::stip_stat_type  stat
);

   import stip_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPD,
      ST_CEL_INIT,
      ST_CEL,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FIN,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_LOOKUP) begin
                  cmd.load     = 1'b1;
                  cmd.scan_clr = 1'b1;
                  state_in     = ST_SPD;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_SPD: begin
            cmd.spd_scan = 1'b1;
            if (stat.spd_done) begin
               state_in = ST_CEL_INIT;
            end
         end
         ST_CEL_INIT: begin
            cmd.scan_clr = 1'b1;
            state_in     = ST_CEL;
         end
         ST_CEL: begin
            cmd.cel_scan = 1'b1;
            if (stat.cel_done) begin
               state_in = stat.cel_empty ? ST_OUT : ST_FETCH0;
            end
         end
         ST_FETCH0: begin
            cmd.cap_sec = 1'b1;
            state_in    = ST_FETCH1;
         end
         ST_FETCH1: begin
            cmd.sel_second = 1'b1;
            cmd.cap_y0     = 1'b1;
            state_in       = ST_FETCH2;
         end
         ST_FETCH2: begin
            cmd.cap_y1 = 1'b1;
            state_in   = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/stip_dp.sv -----
`default_nettype none

module stip_dp #(
   parameter int MAX_SPEEDS = stip_pkg::SPEEDS_DEFAULT,
   parameter int MAX_STEERS = stip_pkg::STEERS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire stip_pkg::stip_cmd_type           cmd,
   output stip_pkg::stip_stat_type               stat,
   input  wire stip_pkg::stip_req_type           req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output stip_pkg::stip_rsp_type                rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [stip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [stip_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import stip_pkg::*;

   localparam int SW  = (MAX_SPEEDS > 1) ? $clog2(MAX_SPEEDS) : 1;
   localparam int RW  = $clog2(MAX_STEERS);
   localparam int NSW = $clog2(MAX_SPEEDS + 1);
   localparam int NRW = $clog2(MAX_STEERS + 1);
   localparam int IW  = ((NSW > NRW) ? NSW : NRW) + 1;
   localparam int CELL_DEPTH = 1 << (SW + RW);
   localparam int PW  = 51;
   localparam int DW  = 25;
   localparam logic signed [52:0] SAT_HI = 53'sd8388607;
   localparam logic signed [52:0] SAT_LO = -53'sd8388608;

   logic [VAL_W-1:0] sp_mem [MAX_SPEEDS];
   logic [VAL_W-1:0] st_mem [MAX_STEERS];
   logic [VAL_W:0]   cl_mem [CELL_DEPTH];

   logic [SPD_REG_W-1:0] spd_cnt_ff;
   logic [STR_REG_W-1:0] str_cnt_ff;
   logic [NSW-1:0]       ns;
   logic [NRW-1:0]       nr;

   logic             sp_we, st_we, cl_we;
   logic [VAL_W-1:0] sp_q_ff, st_q_ff;
   logic [VAL_W:0]   cl_q_ff;
   logic [RW-1:0]    st_raddr;

   logic             pos_ff;
   logic [VAL_W-1:0] a_ff, a_in;
   logic [VAL_W-1:0] speed_ff;

   logic [IW-1:0] idx_ff, cidx_ff;
   logic          cvld_ff;
   logic          spd_issue, cel_issue;

   logic [24:0]   sp_diff, sp_dist, sbd_ff;
   logic [SW-1:0] col_ff;
   logic          spd_cmp;

   logic [VAL_W-1:0] cl_x;
   logic [25:0]      cl_diff, cl_neg;
   logic [24:0]      cl_dist;
   logic             cel_cmp, cel_stop, cel_upd;

   logic [IW-1:0]    best_ff, n_ff, second_ff, sec;
   logic [24:0]      bd_ff, pd_ff, dl_ff, dr_ff;
   logic [VAL_W-1:0] bx_ff, px_ff, xl_ff, xr_ff, x1;
   logic             after_ff, empty_ff;

   logic signed [24:0] den_ff, den;
   logic               direct_ff;
   logic [VAL_W-1:0]   y0_ff;
   logic signed [24:0] dy;
   logic signed [25:0] dx;
   logic signed [50:0] prod_ff;
   logic [PW-1:0]      pmag, quo;
   logic [DW-1:0]      dmag;
   logic               div_done;

   logic signed [52:0] y0e, qe, r, rs, r_ff;
   logic [VAL_W-1:0]   sat;
   logic               rsp_valid_ff;
   stip_rsp_type       rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         spd_cnt_ff <= SPD_REG_W'(1);
         str_cnt_ff <= STR_REG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEEDS: spd_cnt_ff <= csr_wdata[SPD_REG_W-1:0];
            CSR_STEERS: str_cnt_ff <= csr_wdata[STR_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign ns = (spd_cnt_ff == '0) ? NSW'(1) :
               (32'(spd_cnt_ff) > MAX_SPEEDS) ? NSW'(MAX_SPEEDS) : NSW'(spd_cnt_ff);
   assign nr = (str_cnt_ff == '0) ? NRW'(1) :
               (32'(str_cnt_ff) > MAX_STEERS) ? NRW'(MAX_STEERS) : NRW'(str_cnt_ff);

   // table memories
   assign sp_we = cmd.wr && (req_data.action == ACT_WR_SPEED) &&
                  (32'(req_data.col_index) < MAX_SPEEDS);
   assign st_we = cmd.wr && (req_data.action == ACT_WR_STEER) &&
                  (32'(req_data.row_index) < MAX_STEERS);
   assign cl_we = cmd.wr && (req_data.action == ACT_WR_CELL) &&
                  (32'(req_data.col_index) < MAX_SPEEDS) &&
                  (32'(req_data.row_index) < MAX_STEERS);

   assign st_raddr = cmd.sel_second ? second_ff[RW-1:0] : best_ff[RW-1:0];

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sp_mem[SW'(req_data.col_index)] <= req_data.table_value;
      end
      sp_q_ff <= sp_mem[idx_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[RW'(req_data.row_index)] <= req_data.table_value;
      end
      st_q_ff <= st_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (cl_we) begin
         cl_mem[{SW'(req_data.col_index), RW'(req_data.row_index)}] <=
            {req_data.cell_valid, req_data.table_value};
      end
      cl_q_ff <= cl_mem[{col_ff, idx_ff[RW-1:0]}];
   end

   // lookup operands
   assign a_in = req_data.lookup_accel[VAL_W-1] ? (~req_data.lookup_accel + VAL_W'(1))
                                                : req_data.lookup_accel;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff   <= !req_data.lookup_accel[VAL_W-1] && (req_data.lookup_accel != '0);
         a_ff     <= a_in;
         speed_ff <= req_data.lookup_speed;
      end
   end

   // scan address and compare pipeline
   assign spd_issue = cmd.spd_scan && (idx_ff < IW'(ns));
   assign cel_issue = cmd.cel_scan && (idx_ff <= IW'(nr));

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         cvld_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         idx_ff  <= '0;
         cvld_ff <= 1'b0;
      end else begin
         cvld_ff <= spd_issue || cel_issue;
         if (spd_issue || cel_issue) begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff <= idx_ff;
   end

   // nearest speed column
   assign sp_diff = {sp_q_ff[VAL_W-1], sp_q_ff} - {speed_ff[VAL_W-1], speed_ff};
   assign sp_dist = sp_diff[24] ? (~sp_diff + 25'd1) : sp_diff;
   assign spd_cmp = cvld_ff && cmd.spd_scan;

   always_ff @(posedge clock) begin
      if (spd_cmp && ((cidx_ff == '0) || (sp_dist < sbd_ff))) begin
         sbd_ff <= sp_dist;
         col_ff <= cidx_ff[SW-1:0];
      end
   end

   // nearest cell in the column
   assign cl_x     = cl_q_ff[VAL_W-1:0];
   assign cl_diff  = {{2{cl_x[VAL_W-1]}}, cl_x} - {2'b00, a_ff};
   assign cl_neg   = ~cl_diff + 26'd1;
   assign cl_dist  = cl_diff[25] ? cl_neg[24:0] : cl_diff[24:0];
   assign cel_cmp  = cvld_ff && cmd.cel_scan;
   assign cel_stop = cel_cmp && ((cidx_ff == IW'(nr)) || !cl_q_ff[VAL_W]);
   assign cel_upd  = cel_cmp && !cel_stop;

   always_ff @(posedge clock) begin
      if (cel_upd) begin
         if ((cidx_ff == '0) || (cl_dist < bd_ff)) begin
            best_ff  <= cidx_ff;
            bd_ff    <= cl_dist;
            bx_ff    <= cl_x;
            dl_ff    <= pd_ff;
            xl_ff    <= px_ff;
            after_ff <= 1'b1;
         end else if (after_ff) begin
            dr_ff    <= cl_dist;
            xr_ff    <= cl_x;
            after_ff <= 1'b0;
         end
         pd_ff <= cl_dist;
         px_ff <= cl_x;
      end
      if (cel_stop) begin
         n_ff     <= cidx_ff;
         empty_ff <= (cidx_ff == '0);
      end
   end

   // neighbour choice
   always_comb begin
      if (best_ff == '0) begin
         sec = best_ff;
         x1  = bx_ff;
      end else if ((best_ff == (n_ff - IW'(1))) || !(dr_ff < dl_ff)) begin
         sec = best_ff - IW'(1);
         x1  = xl_ff;
      end else begin
         sec = best_ff + IW'(1);
         x1  = xr_ff;
      end
   end

   assign den = {x1[VAL_W-1], x1} - {bx_ff[VAL_W-1], bx_ff};

   always_ff @(posedge clock) begin
      if (cmd.cap_sec) begin
         second_ff <= sec;
         den_ff    <= den;
         direct_ff <= (sec == best_ff) || (x1 == bx_ff);
      end
      if (cmd.cap_y0) begin
         y0_ff <= st_q_ff;
      end
      if (cmd.cap_y1) begin
         prod_ff <= dy * dx;
      end
   end

   assign dy = {st_q_ff[VAL_W-1], st_q_ff} - {y0_ff[VAL_W-1], y0_ff};
   assign dx = {2'b00, a_ff} - {{2{bx_ff[VAL_W-1]}}, bx_ff};

   // truncating divide on magnitudes
   assign pmag = prod_ff[50] ? (~prod_ff + PW'(1)) : prod_ff;
   assign dmag = den_ff[24] ? (~den_ff + DW'(1)) : den_ff;

   stip_div #(
      .NW (PW),
      .DW (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (pmag),
      .divisor  (dmag),
      .done     (div_done),
      .quotient (quo)
   );

   // final sum, sign and saturation
   assign y0e = {{29{y0_ff[VAL_W-1]}}, y0_ff};
   assign qe  = {2'b00, quo};
   assign r   = direct_ff ? y0e :
                (prod_ff[50] ^ den_ff[24]) ? (y0e - qe) : (y0e + qe);
   assign rs  = pos_ff ? r : -r;

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         r_ff <= rs;
      end
   end

   assign sat = (r_ff > SAT_HI) ? SAT_HI[VAL_W-1:0] :
                (r_ff < SAT_LO) ? SAT_LO[VAL_W-1:0] : r_ff[VAL_W-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.steer_out <= empty_ff ? '0 : sat;
         rsp_data_ff.status    <= empty_ff ? STATUS_EMPTY : STATUS_OK;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.spd_done  = spd_cmp && (cidx_ff == (IW'(ns) - IW'(1)));
   assign stat.cel_done  = cel_stop;
   assign stat.cel_empty = (cidx_ff == '0);
   assign stat.div_done  = div_done;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

// ----- src/steer_table_interpolator_top.sv -----
`default_nettype none

// Two-dimensional steer lookup table with linear interpolation. Header and cell
// write transactions complete as they are accepted and produce no response. A
// lookup transaction scans the speed headers for the nearest column, then the
// valid cells of that column (at most steers_in_use), then interpolates:
// each table scan reads one entry per cycle from its memory port, and the
// interpolation divide is a restoring divider producing one quotient bit per
// cycle over 51 bits. One lookup is in flight at a time; a finished response
// may wait in the output register while the next transaction is accepted.
// Table memories are not cleared at reset: every header and cell in use must be
// written before the first lookup.
module steer_table_interpolator_top #(
   parameter int MAX_SPEEDS = stip_pkg::SPEEDS_DEFAULT,
   parameter int MAX_STEERS = stip_pkg::STEERS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire stip_pkg::stip_req_type           req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output stip_pkg::stip_rsp_type                rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [stip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [stip_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import stip_pkg::*;

   stip_cmd_type  cmd;
   stip_stat_type stat;

   assign csr_ready = !reset;

   stip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   stip_dp #(
      .MAX_SPEEDS (MAX_SPEEDS),
      .MAX_STEERS (MAX_STEERS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_EMPTY)) |-> (rsp_data.steer_out == '0))
      else $error("empty-column response carries a nonzero angle");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.action == ACT_LOOKUP)) |=> req_stall)
      else $error("lookup did not occupy the controller");

   a_write_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.action != ACT_LOOKUP)) |=> !req_stall)
      else $error("write transaction stalled the next one");

endmodule

`default_nettype wire

// ----- tb/stip_checker.sv -----
`default_nettype none

module stip_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire stip_pkg::stip_req_type           req_data,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire stip_pkg::stip_rsp_type           rsp_data,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [stip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [stip_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                    mismatches,
   output int                                    pending
);
   import stip_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSPD = SPEEDS_DEFAULT;
   localparam int NSTR = STEERS_DEFAULT;

   logic signed [VAL_W-1:0] speed_hdr [NSPD];
   logic signed [VAL_W-1:0] steer_hdr [NSTR];
   logic signed [VAL_W-1:0] cell_val [NSPD][NSTR];
   bit                      cell_ok [NSPD][NSTR];
   logic [SPD_REG_W-1:0]    speeds_reg;
   logic [STR_REG_W-1:0]    steers_reg;
   stip_rsp_type            steer_q[$];

   function automatic longint absd(input longint a, input longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic stip_rsp_type interpolate_steer(input stip_req_type r);
      longint accel_v, spd_v, mag, best_d, d, dl, dr, x0, x1, y0, y1, res;
      int ns, nr, col, n, best, second;
      bit positive;
      stip_rsp_type o;
      accel_v  = longint'(r.lookup_accel);
      spd_v    = longint'(r.lookup_speed);
      positive = accel_v > 0;
      mag      = (accel_v < 0) ? -accel_v : accel_v;
      ns = (speeds_reg == 0) ? 1 : ((speeds_reg > NSPD) ? NSPD : int'(speeds_reg));
      nr = (steers_reg == 0) ? 1 : ((steers_reg > NSTR) ? NSTR : int'(steers_reg));
      col = 0;
      best_d = absd(longint'(speed_hdr[0]), spd_v);
      for (int j = 1; j < ns; j++) begin
         d = absd(longint'(speed_hdr[j]), spd_v);
         if (d < best_d) begin
            best_d = d;
            col = j;
         end
      end
      n = 0;
      while (n < nr && cell_ok[col][n]) n++;
      if (n == 0) begin
         o.steer_out = '0;
         o.status = STATUS_EMPTY;
         return o;
      end
      best = 0;
      best_d = absd(longint'(cell_val[col][0]), mag);
      for (int j = 1; j < n; j++) begin
         d = absd(longint'(cell_val[col][j]), mag);
         if (d < best_d) begin
            best_d = d;
            best = j;
         end
      end
      if (best == 0) begin
         second = 0;
      end else if (best == n - 1) begin
         second = best - 1;
      end else begin
         dl = absd(longint'(cell_val[col][best-1]), mag);
         dr = absd(longint'(cell_val[col][best+1]), mag);
         second = (dr < dl) ? best + 1 : best - 1;
      end
      x0 = longint'(cell_val[col][best]);
      x1 = longint'(cell_val[col][second]);
      y0 = longint'(steer_hdr[best]);
      y1 = longint'(steer_hdr[second]);
      if (best == second || x1 == x0) res = y0;
      else res = y0 + ((y1 - y0) * (mag - x0)) / (x1 - x0);
      if (!positive) res = -res;
      if (res > 64'sd8388607) res = 64'sd8388607;
      if (res < -64'sd8388608) res = -64'sd8388608;
      o.steer_out = res[VAL_W-1:0];
      o.status = STATUS_OK;
      return o;
   endfunction

   always @(posedge clock) begin
      stip_rsp_type want;
      if (reset) begin
         speeds_reg <= SPD_REG_W'(1);
         steers_reg <= STR_REG_W'(1);
         steer_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPEEDS) speeds_reg <= csr_wdata[SPD_REG_W-1:0];
            else if (csr_index == CSR_STEERS) steers_reg <= csr_wdata[STR_REG_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (steer_q.size() == 0) begin
               if (mismatches < 10)
                  $display("ERROR: unexpected response steer=%0d status=%0d",
                           rsp_data.steer_out, rsp_data.status);
               mismatches++;
            end else begin
               want = steer_q.pop_front();
               if (rsp_data.steer_out !== want.steer_out ||
                   rsp_data.status !== want.status) begin
                  if (mismatches < 10)
                     $display("ERROR: steer exp=%0d got=%0d status exp=%0d got=%0d",
                              want.steer_out, rsp_data.steer_out,
                              want.status, rsp_data.status);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.action)
               ACT_WR_SPEED: speed_hdr[req_data.col_index] = req_data.table_value;
               ACT_WR_STEER: steer_hdr[req_data.row_index] = req_data.table_value;
               ACT_WR_CELL: begin
                  cell_val[req_data.col_index][req_data.row_index] = req_data.table_value;
                  cell_ok[req_data.col_index][req_data.row_index]  = req_data.cell_valid;
               end
               default: steer_q = {steer_q, interpolate_steer(req_data)};
            endcase
         end
      end
      pending <= steer_q.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
   import stip_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSPD = SPEEDS_DEFAULT;
   localparam int NSTR = STEERS_DEFAULT;
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   stip_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   stip_rsp_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    pending;

   int  speed_w [NSPD];
   int  cell_w [NSPD][NSTR];
   bit  offering;
   bit  hold_now;
   int  burst_left;
   int  quiet;

   steer_table_interpolator_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   stip_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return int'(v);
   endfunction

   function automatic int rand24();
      return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
   endfunction

   // one transaction; caller is at a rising edge
   task automatic send(input stip_req_type it);
      bit taken;
      int gap;
      req_data  <= it;
      req_valid <= 1'b1;
      offering = 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic stop_offer();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic put(input stip_action_type act, input int row, input int col,
                      input int value, input bit ok);
      stip_req_type it;
      it.action       = act;
      it.row_index    = 6'(row);
      it.col_index    = 4'(col);
      it.table_value  = 24'(value);
      it.cell_valid   = ok;
      it.lookup_accel = 24'($urandom);
      it.lookup_speed = 24'($urandom);
      if (act == ACT_WR_SPEED) speed_w[col] = value;
      if (act == ACT_WR_CELL) cell_w[col][row] = value;
      send(it);
   endtask

   task automatic lookup(input int speed, input int accel);
      stip_req_type it;
      it.action       = ACT_LOOKUP;
      it.row_index    = 6'($urandom);
      it.col_index    = 4'($urandom);
      it.table_value  = 24'($urandom);
      it.cell_valid   = 1'($urandom);
      it.lookup_accel = 24'(accel);
      it.lookup_speed = 24'(speed);
      send(it);
   endtask

   task automatic settle();
      stop_offer();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_table(input int ns, input int nr);
      longint v;
      int cut;
      v = rand24() / 2;
      for (int c = 0; c < ns; c++) begin
         if ($urandom_range(0, 5) == 0) put(ACT_WR_SPEED, 0, c, rand24(), 1'($urandom));
         else put(ACT_WR_SPEED, 0, c, clamp24(v), 1'($urandom));
         v += $urandom_range(0, 300000);
      end
      v = rand24() / 2;
      for (int r = 0; r < nr; r++) begin
         case ($urandom_range(0, 9))
            0: put(ACT_WR_STEER, r, 0, 8388607, 1'($urandom));
            1: put(ACT_WR_STEER, r, 0, -8388608, 1'($urandom));
            2: put(ACT_WR_STEER, r, 0, rand24(), 1'($urandom));
            default: put(ACT_WR_STEER, r, 0, clamp24(v), 1'($urandom));
         endcase
         v += longint'($urandom_range(0, 400000)) - 100000;
      end
      for (int c = 0; c < ns; c++) begin
         case ($urandom_range(0, 7))
            0: cut = 0;
            1, 2: cut = $urandom_range(1, nr);
            default: cut = nr;
         endcase
         v = longint'($urandom_range(0, 2000000)) - 500000;
         for (int r = 0; r < nr; r++) begin
            if (r < cut) put(ACT_WR_CELL, r, c, clamp24(v), 1'b1);
            else if (r == cut) put(ACT_WR_CELL, r, c, rand24(), 1'b0);
            else put(ACT_WR_CELL, r, c, rand24(), 1'($urandom));
            if ($urandom_range(0, 9) == 0) v = rand24();
            else v += $urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 250000);
         end
      end
   endtask

   task automatic run_phase(input int speeds_val, input int steers_val, input int lookups);
      int ns, nr, c, r, spd, acc;
      ns = (speeds_val == 0) ? 1 : ((speeds_val > NSPD) ? NSPD : speeds_val);
      nr = (steers_val == 0) ? 1 : ((steers_val > NSTR) ? NSTR : steers_val);
      csr_write(CSR_SPEEDS, speeds_val);
      csr_write(CSR_STEERS, steers_val);
      load_table(ns, nr);
      for (int k = 0; k < lookups; k++) begin
         if ($urandom_range(0, 7) == 0)
            put(ACT_WR_CELL, $urandom_range(0, nr - 1), $urandom_range(0, ns - 1),
                rand24(), $urandom_range(0, 4) != 0);
         c = $urandom_range(0, ns - 1);
         r = $urandom_range(0, nr - 1);
         case ($urandom_range(0, 5))
            0: spd = rand24();
            1: spd = $urandom_range(0, 1) ? 8388607 : -8388608;
            default: spd = clamp24(longint'(speed_w[c]) + $urandom_range(0, 20000) - 10000);
         endcase
         case ($urandom_range(0, 9))
            0: acc = rand24();
            1: acc = 0;
            2: acc = $urandom_range(0, 1) ? 8388607 : -8388608;
            default: acc = clamp24(longint'(cell_w[c][r]) + $urandom_range(0, 60000) - 30000);
         endcase
         if ($urandom_range(0, 2) == 0) acc = clamp24(-longint'(acc));
         lookup(spd, acc);
      end
      settle();
   endtask

   // receiver stall pattern, with one long hold-off
   initial begin
      int mode, len;
      bit held;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         if (hold_now && !held) begin
            held = 1'b1;
            repeat (1500) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(5, 80);
         repeat (len) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom);
               2: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("steer_table_interpolator_top verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      offering   = 1'b0;
      hold_now   = 1'b0;
      burst_left = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: two columns, four rows, second column empty
      csr_write(CSR_SPEEDS, 2);
      csr_write(CSR_STEERS, 4);
      put(ACT_WR_SPEED, 0, 0, -8388608, 1'b0);
      put(ACT_WR_SPEED, 63, 1, 8388607, 1'b1);
      put(ACT_WR_STEER, 0, 15, -8388608, 1'b0);
      put(ACT_WR_STEER, 1, 0, 65536, 1'b1);
      put(ACT_WR_STEER, 2, 0, 8388607, 1'b0);
      put(ACT_WR_STEER, 3, 0, 0, 1'b1);
      put(ACT_WR_CELL, 0, 0, 'h10000, 1'b1);
      put(ACT_WR_CELL, 1, 0, 'h20000, 1'b1);
      put(ACT_WR_CELL, 2, 0, 'h30000, 1'b1);
      put(ACT_WR_CELL, 3, 0, 'h30000, 1'b1);
      put(ACT_WR_CELL, 0, 1, -1, 1'b0);
      lookup(-8388608, 0);
      lookup(-100, 'h18000);
      lookup(0, -'h1C000);
      lookup(5, 8388607);
      lookup(8388607, 100);
      lookup(1, -8388608);
      put(ACT_WR_CELL, 3, 0, 'h38000, 1'b1);
      lookup(0, 8388607);
      lookup(0, 'h34000);
      lookup(0, -'h38000);
      lookup(-8388608, 'h2FFFF);
      settle();

      run_phase(17, 2, 40);
      run_phase(0, 127, 30);
      hold_now = 1'b1;
      run_phase(5, 10, 60);
      run_phase(2, 3, 30);

      if (mismatches == 0) begin
         $display("steer_table_interpolator_top verification clean");
      end else begin
         $display("steer_table_interpolator_top verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
